// ===== hdl/q2rm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Holds widths, constants and the payload types; no dependencies.
package q2rm_pkg;
    localparam int unsigned QW = 16;
    localparam int unsigned NW = 21;   // squared norm, up to 4 * 2^18
    localparam int unsigned SW = 26;   // scale, up to 2^25
    localparam int unsigned PW = 30;   // scaled component
    localparam int unsigned EW = 34;   // product term
    localparam int unsigned DIV_STEPS = 26;
    localparam logic [SW-1:0] S_NUM = 26'h2000000;
    localparam logic signed [EW+1:0] Q_ONE = 36'sd4096;

    typedef struct packed {
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [QW-1:0] qw;
    } t_quat;

    typedef struct packed {
        logic signed [QW-1:0] m00;
        logic signed [QW-1:0] m01;
        logic signed [QW-1:0] m02;
        logic signed [QW-1:0] m10;
        logic signed [QW-1:0] m11;
        logic signed [QW-1:0] m12;
        logic signed [QW-1:0] m20;
        logic signed [QW-1:0] m21;
        logic signed [QW-1:0] m22;
        logic              norm_zero;
    } t_mat;

    // Signed truncating divide by 4096: add 4095 to negatives before the shift.
    function automatic logic signed [63:0] qdiv(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? 64'sd4095 : 64'sd0);
        return t >>> 12;
    endfunction

    function automatic logic signed [QW-1:0] sat16(input logic signed [EW+1:0] v);
        logic signed [QW-1:0] r;
        if (v > 36'sd32767) r = 16'sh7fff;
        else if (v < -36'sd32768) r = -16'sh8000;
        else r = v[QW-1:0];
        return r;
    endfunction
endpackage

// ===== hdl/q2rm_if.sv =====
// Valid/ready channel carrying one payload beat.
// Depends on nothing; the payload type is a type parameter.
interface q2rm_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/q2rm_div.sv =====
// Pipelined restoring divider: 2^25 / norm, one quotient bit per stage.
// Depends on q2rm_pkg. Side data travels alongside each stage.
module q2rm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [q2rm_pkg::NW-1:0]    i_den,
    input  q2rm_pkg::t_quat            i_q,
    output logic                       o_vld,
    output logic [q2rm_pkg::SW-1:0]    o_quo,
    output q2rm_pkg::t_quat            o_q,
    output logic                       o_zero
);
    import q2rm_pkg::*;
    logic               r_vld [DIV_STEPS];
    logic [NW:0]        r_rem [DIV_STEPS];
    logic [SW-1:0]      r_quo [DIV_STEPS];
    logic [NW-1:0]      r_den [DIV_STEPS];
    t_quat              r_q   [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DIV_STEPS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage k brings down dividend bit SW-1-k and decides one quotient bit.
    always_ff @(posedge i_clk) begin
        logic [NW:0] t;
        if (i_en) begin
            t = {{NW{1'b0}}, S_NUM[SW-1]};
            if (t >= {1'b0, i_den}) begin
                r_rem[0] <= t - {1'b0, i_den};
                r_quo[0] <= {{(SW-1){1'b0}}, 1'b1};
            end else begin
                r_rem[0] <= t;
                r_quo[0] <= '0;
            end
            r_den[0] <= i_den;
            r_q[0]   <= i_q;
            for (int k = 1; k < DIV_STEPS; k++) begin
                t = {r_rem[k-1][NW-1:0], S_NUM[SW-1-k]};
                if (t >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= t - {1'b0, r_den[k-1]};
                    r_quo[k] <= {r_quo[k-1][SW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t;
                    r_quo[k] <= {r_quo[k-1][SW-2:0], 1'b0};
                end
                r_den[k] <= r_den[k-1];
                r_q[k]   <= r_q[k-1];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quo  = r_quo[DIV_STEPS-1];
    assign o_q    = r_q[DIV_STEPS-1];
    assign o_zero = (r_den[DIV_STEPS-1] == '0);
endmodule

// ===== hdl/q2rm_mat.sv =====
// Product stages: scaled components, pair products, sums and saturation.
// Depends on q2rm_pkg. Three register stages under one enable.
module q2rm_mat (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [q2rm_pkg::SW-1:0] i_s,
    input  q2rm_pkg::t_quat         i_q,
    input  logic                    i_zero,
    output logic                    o_vld,
    output q2rm_pkg::t_mat          o_mat
);
    import q2rm_pkg::*;
    logic              r_v1, r_v2, r_v3;
    logic              r_z1, r_z2;
    t_quat             r_q1;
    logic signed [PW-1:0] r_sx, r_sy, r_sz;
    logic signed [EW-1:0] r_wx, r_wy, r_wz, r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;
    t_mat              r_mat;
    logic signed [63:0] n_s;

    assign n_s = {{(64-SW){1'b0}}, i_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [EW+1:0] a, b;
        if (i_en) begin
            // scale each vector component
            r_sx <= PW'(qdiv(64'(i_q.qx) * n_s));
            r_sy <= PW'(qdiv(64'(i_q.qy) * n_s));
            r_sz <= PW'(qdiv(64'(i_q.qz) * n_s));
            r_q1 <= i_q;
            r_z1 <= i_zero;
            // pair products
            r_wx <= EW'(qdiv(64'(r_q1.qw) * 64'(r_sx)));
            r_wy <= EW'(qdiv(64'(r_q1.qw) * 64'(r_sy)));
            r_wz <= EW'(qdiv(64'(r_q1.qw) * 64'(r_sz)));
            r_xx <= EW'(qdiv(64'(r_q1.qx) * 64'(r_sx)));
            r_xy <= EW'(qdiv(64'(r_q1.qx) * 64'(r_sy)));
            r_xz <= EW'(qdiv(64'(r_q1.qx) * 64'(r_sz)));
            r_yy <= EW'(qdiv(64'(r_q1.qy) * 64'(r_sy)));
            r_yz <= EW'(qdiv(64'(r_q1.qy) * 64'(r_sz)));
            r_zz <= EW'(qdiv(64'(r_q1.qz) * 64'(r_sz)));
            r_z2 <= r_z1;
            // sums, saturation; zero norm forces zeros
            a = 36'(r_yy) + 36'(r_zz);
            r_mat.m00 <= r_z2 ? '0 : sat16(Q_ONE - a);
            r_mat.m01 <= r_z2 ? '0 : sat16(36'(r_xy) + 36'(r_wz));
            r_mat.m02 <= r_z2 ? '0 : sat16(36'(r_xz) - 36'(r_wy));
            r_mat.m10 <= r_z2 ? '0 : sat16(36'(r_xy) - 36'(r_wz));
            b = 36'(r_zz) + 36'(r_xx);
            r_mat.m11 <= r_z2 ? '0 : sat16(Q_ONE - b);
            r_mat.m12 <= r_z2 ? '0 : sat16(36'(r_yz) + 36'(r_wx));
            r_mat.m20 <= r_z2 ? '0 : sat16(36'(r_xz) + 36'(r_wy));
            r_mat.m21 <= r_z2 ? '0 : sat16(36'(r_yz) - 36'(r_wx));
            r_mat.m22 <= r_z2 ? '0 : sat16(Q_ONE - (36'(r_xx) + 36'(r_yy)));
            r_mat.norm_zero <= r_z2;
        end
    end

    assign o_vld = r_v3;
    assign o_mat = r_mat;
endmodule

// ===== hdl/quaternion_to_rotation_matrix.sv =====
// Quaternion to rotation matrix top level: norm, divider, product stages.
// Depends on q2rm_pkg, q2rm_if, q2rm_div and q2rm_mat.
//
// One quaternion beat is taken every cycle unless the sink stalls; its matrix beat
// passes one norm stage, 26 stages of the bit-per-stage divider that forms the
// scale, and three product stages. The pipeline advances whenever its last stage is
// empty or the sink takes the beat, so a stall holds every stage in place.
module quaternion_to_rotation_matrix (
    input  logic  i_clk,
    input  logic  i_rst_n,
    q2rm_if.sink   i_quat,
    q2rm_if.source o_mat
);
    import q2rm_pkg::*;
    logic        w_en;
    logic        r_nv;
    logic [NW-1:0] r_norm;
    t_quat       r_q0;
    logic        w_dv, w_zero;
    logic [SW-1:0] w_s;
    t_quat       w_q;

    assign w_en = !o_mat.valid || o_mat.ready;
    assign i_quat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (w_en) begin
            r_nv <= i_quat.valid;
        end
    end

    // squared norm: each square is non-negative, so the shift truncates
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm <= NW'((32'(i_quat.data.qx * i_quat.data.qx) >> 12)
                        + (32'(i_quat.data.qy * i_quat.data.qy) >> 12)
                        + (32'(i_quat.data.qz * i_quat.data.qz) >> 12)
                        + (32'(i_quat.data.qw * i_quat.data.qw) >> 12));
            r_q0 <= i_quat.data;
        end
    end

    q2rm_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_nv), .i_den(r_norm), .i_q(r_q0),
        .o_vld(w_dv), .o_quo(w_s), .o_q(w_q), .o_zero(w_zero)
    );

    q2rm_mat u_mat (
        .i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_dv), .i_s(w_s), .i_q(w_q),
        .i_zero(w_zero), .o_vld(o_mat.valid), .o_mat(o_mat.data)
    );
endmodule
